>>> design/run_length_smoothing_top_assert.svh
// Assertion macros for the run-length smoothing block.
// Used by the port checker; no other dependencies.
`ifndef RUN_LENGTH_SMOOTHING_TOP_ASSERT_SVH
`define RUN_LENGTH_SMOOTHING_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RLS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RLS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/rls_pkg.sv
// Shared constants, codes and types of the run-length smoothing block.
// No dependencies.
package rls_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;

  localparam int COL_W  = 9;
  localparam int ROW_W  = 9;
  localparam int IDX_W  = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int CFG_W  = 10;
  localparam int LEN_W  = CFG_W;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HLIMIT,
    REG_VLIMIT,
    REG_WIDTH,
    REG_HEIGHT
  } cfg_reg_t;

  typedef enum logic {
    ACT_LOAD,
    ACT_QUERY
  } action_t;

  typedef enum logic [2:0] {
    SC_IDLE,
    SC_ISSUE,
    SC_DRAIN,
    SC_DECIDE,
    SC_FINISH
  } scan_state_t;

  typedef struct packed {
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
  } coord_t;

  typedef struct packed {
    coord_t pos;
    logic   hb;
    logic   vb;
  } result_t;

  typedef struct packed {
    logic [LEN_W-1:0] width;
    logic [LEN_W-1:0] height;
    logic [LEN_W-1:0] hlimit;
    logic [LEN_W-1:0] vlimit;
  } geom_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } rd_req_t;

endpackage

>>> design/rls_frame_ram.sv
// Single-write, single-read synchronous RAM with registered read data.
// Generic; holds the frame store. No package dependency.
module rls_frame_ram #(
  parameter int ADDR_W = 18,
  parameter int DATA_W = 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> design/rls_scan.sv
// Query sequencer: sweeps the queried row, then the queried column, through
// the frame store and decides both smears. Depends on rls_pkg.
module rls_scan (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            req_valid,
  input  rls_pkg::coord_t req,
  input  rls_pkg::geom_t  geom,
  output logic            scan_ready,
  output logic            res_valid,
  input  logic            res_ready,
  output rls_pkg::result_t res,
  output rls_pkg::rd_req_t rd_req,
  input  logic            rd_data
);

  rls_pkg::scan_state_t state_r, state_nxt;

  rls_pkg::coord_t                pos_r;
  logic                           vert_r;
  logic [rls_pkg::IDX_W-1:0]      idx_r;
  logic                           rd_vld_r;
  logic [rls_pkg::IDX_W-1:0]      rd_idx_r;
  logic                           have_last_r;
  logic [rls_pkg::IDX_W-1:0]      last_r;
  logic                           found_end_r;
  logic [rls_pkg::IDX_W-1:0]      end_r;
  logic                           center_r;
  logic                           hb_r;
  logic                           vb_r;

  logic [rls_pkg::LEN_W-1:0] line_len;
  logic [rls_pkg::LEN_W-1:0] line_limit;
  logic [rls_pkg::IDX_W-1:0] line_pos;
  logic                      last_issue;
  logic                      in_image;
  logic [rls_pkg::LEN_W-1:0] run_start;
  logic [rls_pkg::LEN_W-1:0] run_len;
  logic                      run_black;

  always_comb begin
    line_len   = vert_r ? geom.height : geom.width;
    line_limit = vert_r ? geom.vlimit : geom.hlimit;
    line_pos   = vert_r ? rls_pkg::IDX_W'(pos_r.row) : rls_pkg::IDX_W'(pos_r.column);
    last_issue = (rls_pkg::LEN_W'(idx_r) == (line_len - rls_pkg::LEN_W'(1)));
    in_image   = (rls_pkg::LEN_W'(req.column) < geom.width) &&
                 (rls_pkg::LEN_W'(req.row) < geom.height);
    // run spans from just past the last black before the pixel up to the
    // first black after it
    run_start  = have_last_r ? (rls_pkg::LEN_W'(last_r) + rls_pkg::LEN_W'(1))
                             : '0;
    run_len    = rls_pkg::LEN_W'(end_r) - run_start;
    run_black  = center_r | (found_end_r & (run_len <= line_limit));
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rls_pkg::SC_IDLE: begin
        if (req_valid) begin
          state_nxt = in_image ? rls_pkg::SC_ISSUE : rls_pkg::SC_FINISH;
        end
      end
      rls_pkg::SC_ISSUE: begin
        if (last_issue) begin
          state_nxt = rls_pkg::SC_DRAIN;
        end
      end
      rls_pkg::SC_DRAIN: begin
        state_nxt = rls_pkg::SC_DECIDE;
      end
      rls_pkg::SC_DECIDE: begin
        state_nxt = vert_r ? rls_pkg::SC_FINISH : rls_pkg::SC_ISSUE;
      end
      rls_pkg::SC_FINISH: begin
        if (res_ready) begin
          state_nxt = rls_pkg::SC_IDLE;
        end
      end
      default: state_nxt = rls_pkg::SC_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    scan_ready  = (state_r == rls_pkg::SC_IDLE);
    res_valid   = (state_r == rls_pkg::SC_FINISH);
    rd_req.en   = (state_r == rls_pkg::SC_ISSUE);
    rd_req.addr = vert_r ? {idx_r[rls_pkg::ROW_W-1:0], pos_r.column}
                         : {pos_r.row, idx_r[rls_pkg::COL_W-1:0]};
    res.pos     = pos_r;
    res.hb      = hb_r;
    res.vb      = vb_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= rls_pkg::SC_IDLE;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= rd_req.en;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= idx_r;
    unique case (state_r)
      rls_pkg::SC_IDLE: begin
        if (req_valid) begin
          pos_r       <= req;
          vert_r      <= 1'b0;
          idx_r       <= '0;
          have_last_r <= 1'b0;
          found_end_r <= 1'b0;
          center_r    <= 1'b0;
          hb_r        <= 1'b0;
          vb_r        <= 1'b0;
        end
      end
      rls_pkg::SC_ISSUE: begin
        if (!last_issue) begin
          idx_r <= idx_r + rls_pkg::IDX_W'(1);
        end
      end
      rls_pkg::SC_DECIDE: begin
        if (vert_r) begin
          vb_r <= run_black;
        end else begin
          hb_r <= run_black;
        end
        vert_r      <= 1'b1;
        idx_r       <= '0;
        have_last_r <= 1'b0;
        found_end_r <= 1'b0;
        center_r    <= 1'b0;
      end
      default: begin
      end
    endcase

    // returning read beat; never overlaps a tracker clear
    if (rd_vld_r) begin
      if (rd_idx_r < line_pos) begin
        if (rd_data) begin
          have_last_r <= 1'b1;
          last_r      <= rd_idx_r;
        end
      end else if (rd_idx_r == line_pos) begin
        center_r <= rd_data;
      end else if (rd_data && !found_end_r) begin
        found_end_r <= 1'b1;
        end_r       <= rd_idx_r;
      end
    end
  end

endmodule

>>> design/run_length_smoothing_top.sv
// Top level of the run-length smoothing block: config registers, frame store,
// query sequencer and result register. Depends on rls_pkg, rls_frame_ram, rls_scan.
//
//   channel | direction | handshake        | payload
//   --------+-----------+------------------+---------------------------------------
//   in_     | input     | in_valid/ready   | action, column, row, pixel_in
//   out_    | output    | out_valid/ready  | column_out, row_out, h/v/smoothed black
//   cfg_    | input     | cfg_write_en     | cfg_index, cfg_data (no wait)
//
// A load beat writes the frame store and the block is ready again at once.
// A query beat sweeps its row (width reads) and then its column (height
// reads) through the single read port of the frame store, one read per cycle.
// A query outside the image in use answers without a sweep.
// Reset is synchronous and active low; the frame store is not cleared.
// in_ready is low while a query is in flight; a finished result waits in the
// output register while the next input beat is taken.
module run_length_smoothing_top (
  input  logic                      clk,
  input  logic                      rst_n,

  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_action,
  input  logic [rls_pkg::COL_W-1:0] in_column,
  input  logic [rls_pkg::ROW_W-1:0] in_row,
  input  logic                      in_pixel_in,

  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [rls_pkg::COL_W-1:0] out_column_out,
  output logic [rls_pkg::ROW_W-1:0] out_row_out,
  output logic                      out_horizontal_black,
  output logic                      out_vertical_black,
  output logic                      out_smoothed_black,

  input  logic                          cfg_write_en,
  input  logic [rls_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rls_pkg::CFG_W-1:0]     cfg_data
);

  localparam logic [rls_pkg::CFG_W-1:0] MAX_W = rls_pkg::CFG_W'(rls_pkg::MAX_WIDTH);
  localparam logic [rls_pkg::CFG_W-1:0] MAX_H = rls_pkg::CFG_W'(rls_pkg::MAX_HEIGHT);

  // configuration registers
  logic [rls_pkg::CFG_W-1:0] hlimit_r;
  logic [rls_pkg::CFG_W-1:0] vlimit_r;
  logic [rls_pkg::CFG_W-1:0] width_r;
  logic [rls_pkg::CFG_W-1:0] height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hlimit_r <= '0;
      vlimit_r <= '0;
      width_r  <= MAX_W;
      height_r <= MAX_H;
    end else if (cfg_write_en) begin
      unique case (rls_pkg::cfg_reg_t'(cfg_index))
        rls_pkg::REG_HLIMIT: hlimit_r <= cfg_data;
        rls_pkg::REG_VLIMIT: vlimit_r <= cfg_data;
        rls_pkg::REG_WIDTH:  width_r  <= cfg_data;
        rls_pkg::REG_HEIGHT: height_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // sizes in use: zero counts as one, anything past the store is clamped
  rls_pkg::geom_t geom;

  always_comb begin
    geom.hlimit = hlimit_r;
    geom.vlimit = vlimit_r;
    priority if (width_r == '0) begin
      geom.width = rls_pkg::CFG_W'(1);
    end else if (width_r > MAX_W) begin
      geom.width = MAX_W;
    end else begin
      geom.width = width_r;
    end
    priority if (height_r == '0) begin
      geom.height = rls_pkg::CFG_W'(1);
    end else if (height_r > MAX_H) begin
      geom.height = MAX_H;
    end else begin
      geom.height = height_r;
    end
  end

  // input beat decode
  logic            in_fire;
  logic            load_fire;
  logic            query_fire;
  rls_pkg::coord_t in_pos;

  assign in_fire    = in_valid && in_ready;
  assign load_fire  = in_fire && (rls_pkg::action_t'(in_action) == rls_pkg::ACT_LOAD);
  assign query_fire = in_fire && (rls_pkg::action_t'(in_action) == rls_pkg::ACT_QUERY);
  assign in_pos.column = in_column;
  assign in_pos.row    = in_row;

  // frame store: loads write only while the sequencer is idle, so a write
  // never meets a sweep read
  rls_pkg::rd_req_t rd_req;
  logic             rd_data;

  rls_frame_ram #(
    .ADDR_W (rls_pkg::ADDR_W),
    .DATA_W (1)
  ) u_frame (
    .clk     (clk),
    .wr_en   (load_fire),
    .wr_addr ({in_row, in_column}),
    .wr_data (in_pixel_in),
    .rd_en   (rd_req.en),
    .rd_addr (rd_req.addr),
    .rd_data (rd_data)
  );

  // query sequencer
  logic             scan_ready;
  logic             res_valid;
  logic             res_ready;
  rls_pkg::result_t res;

  rls_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (query_fire),
    .req        (in_pos),
    .geom       (geom),
    .scan_ready (scan_ready),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .rd_req     (rd_req),
    .rd_data    (rd_data)
  );

  assign in_ready = scan_ready;

  // result register
  logic             out_valid_r;
  rls_pkg::result_t out_res_r;

  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_column_out       = out_res_r.pos.column;
  assign out_row_out          = out_res_r.pos.row;
  assign out_horizontal_black = out_res_r.hb;
  assign out_vertical_black   = out_res_r.vb;
  assign out_smoothed_black   = out_res_r.hb & out_res_r.vb;

endmodule

>>> design/rls_checker.sv
// Port-level checker for run_length_smoothing_top, bound to the top level.
// Depends on rls_pkg and run_length_smoothing_top_assert.svh.
`include "run_length_smoothing_top_assert.svh"

module rls_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_action,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [rls_pkg::COL_W-1:0]     out_column_out,
  input logic [rls_pkg::ROW_W-1:0]     out_row_out,
  input logic                          out_horizontal_black,
  input logic                          out_vertical_black,
  input logic                          out_smoothed_black
);

  logic load_beat;
  logic query_beat;
  logic out_stall;
  logic and_ok;
  logic [rls_pkg::COL_W+rls_pkg::ROW_W+1:0] out_bundle;

  assign load_beat  = in_valid && in_ready &&
                      (rls_pkg::action_t'(in_action) == rls_pkg::ACT_LOAD);
  assign query_beat = in_valid && in_ready &&
                      (rls_pkg::action_t'(in_action) == rls_pkg::ACT_QUERY);
  assign out_stall  = out_valid && !out_ready;
  assign out_bundle = {out_column_out, out_row_out, out_horizontal_black, out_vertical_black};
  assign and_ok     = (out_smoothed_black == (out_horizontal_black && out_vertical_black));

  `RLS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(out_bundle), "result changed while stalled")
  `RLS_ASSERT_IMPLY(a_and, clk, rst_n, out_valid, and_ok, "smoothed result is not the AND")
  `RLS_ASSERT_NEXT(a_query_busy, clk, rst_n, query_beat, !in_ready, "ready right after a query")
  `RLS_ASSERT_NEXT(a_load_ready, clk, rst_n, load_beat, in_ready, "not ready after a load")

endmodule

bind run_length_smoothing_top rls_checker u_rls_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_ready             (in_ready),
  .in_action            (in_action),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_column_out       (out_column_out),
  .out_row_out          (out_row_out),
  .out_horizontal_black (out_horizontal_black),
  .out_vertical_black   (out_vertical_black),
  .out_smoothed_black   (out_smoothed_black)
);
